// ----- rtl/sgrc_pkg.sv -----
package sgrc_pkg;

  // Default operand width and the number of distinct primes kept per item.
  localparam int unsigned ValueBitsDef = 34;
  localparam int unsigned MaxPrimesDef = 10;

endpackage

// ----- rtl/same_gcd_range_count_unit.sv -----
// Counts the values x in the window [a, a+m-1] whose gcd with m equals gcd(a, m), for one
// request of start value a and modulus m; a zero modulus gives 0 and a zero start value
// gives 1. The count is computed as the totient of n = m/g, with g = gcd(a, m): n is
// factored by trial division and reduced once per distinct prime, keeping at most
// MAX_PRIMES of the smallest primes. All arithmetic runs through one shared restoring
// divider; the trial-division loop dominates the run time of an item. The input side is not
// ready while an item is at work. The result waits in an output register, so the next
// request is taken while the result is still waiting to be taken.
module same_gcd_range_count_unit
  import sgrc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned MAX_PRIMES = MaxPrimesDef,
  localparam int unsigned InBits    = ((2 * VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OutBits   = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // Fields from bit 0 up: start_value, modulus, zero padding.
  input  logic [InBits-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // Fields from bit 0 up: match_count, zero padding.
  output logic [OutBits-1:0] m_axis_tdata
);

  localparam int unsigned W       = VALUE_BITS;
  localparam int unsigned CntBits = $clog2(MAX_PRIMES + 1);
  localparam int unsigned DivBits = $clog2(W + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StGcd   = 4'd1;
  localparam logic [3:0] StGcdW  = 4'd2;
  localparam logic [3:0] StNDiv  = 4'd3;
  localparam logic [3:0] StTrial = 4'd4;
  localparam logic [3:0] StTDiv  = 4'd5;
  localparam logic [3:0] StRDiv  = 4'd6;
  localparam logic [3:0] StLast  = 4'd7;
  localparam logic [3:0] StLastW = 4'd8;
  localparam logic [3:0] StDone  = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [W-1:0]       m_q, m_d;
  logic [W-1:0]       x_q, x_d;
  logic [W-1:0]       y_q, y_d;
  logic [W-1:0]       n_q, n_d;
  logic [W-1:0]       r_q, r_d;
  logic [W-1:0]       j_q, j_d;
  logic [W+1:0]       jsq_q, jsq_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;
  logic [W-1:0]       res_q, res_d;

  // Shared divider registers.
  logic [W-1:0]       dd_q, dd_d;
  logic [W-1:0]       dv_q, dv_d;
  logic [W-1:0]       rem_q, rem_d;
  logic [DivBits-1:0] dcnt_q, dcnt_d;

  logic               div_start;
  logic [W-1:0]       div_a, div_b;
  logic               div_done;
  logic [W:0]         trial_sub;
  logic [W-1:0]       in_a, in_m;
  logic               cnt_room;

  assign in_a     = s_axis_tdata[W-1:0];
  assign in_m     = s_axis_tdata[2*W-1:W];
  assign div_done = (dcnt_q == '0);
  assign cnt_room = (cnt_q < CntBits'(MAX_PRIMES));

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBits'(res_q);

  // One restoring division step per cycle: quotient in dd, remainder in rem.
  assign trial_sub = {rem_q, dd_q[W-1]} - {1'b0, dv_q};

  always_comb begin
    dd_d   = dd_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    if (div_start) begin
      dd_d   = div_a;
      dv_d   = div_b;
      rem_d  = '0;
      dcnt_d = DivBits'(W);
    end else if (!div_done) begin
      dcnt_d = dcnt_q - 1'b1;
      if (!trial_sub[W]) begin
        rem_d = trial_sub[W-1:0];
        dd_d  = {dd_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], dd_q[W-1]};
        dd_d  = {dd_q[W-2:0], 1'b0};
      end
    end
  end

  // Sequencer: gcd, n = m / g, trial division and totient reduction.
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    x_d         = x_q;
    y_d         = y_q;
    n_d         = n_q;
    r_d         = r_q;
    j_d         = j_q;
    jsq_d       = jsq_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;
    div_a       = x_q;
    div_b       = y_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          m_d = in_m;
          x_d = in_a;
          y_d = in_m;
          if (in_m == '0) begin
            r_d     = '0;
            state_d = StDone;
          end else begin
            state_d = StGcd;
          end
        end
      end
      StGcd: begin
        div_start = 1'b1;
        if (y_q == '0) begin
          div_a   = m_q;
          div_b   = x_q;
          state_d = StNDiv;
        end else begin
          state_d = StGcdW;
        end
      end
      StGcdW: begin
        if (div_done) begin
          x_d     = y_q;
          y_d     = rem_q;
          state_d = StGcd;
        end
      end
      StNDiv: begin
        if (div_done) begin
          n_d     = dd_q;
          r_d     = dd_q;
          j_d     = W'(2);
          jsq_d   = (W+2)'(4);
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = StTrial;
        end
      end
      StTrial: begin
        if (jsq_q > {2'b00, n_q}) begin
          state_d = StLast;
        end else begin
          div_start = 1'b1;
          div_a     = n_q;
          div_b     = j_q;
          state_d   = StTDiv;
        end
      end
      StTDiv: begin
        if (div_done) begin
          if (rem_q == '0) begin
            // Divide the prime out completely before moving on.
            n_d       = dd_q;
            found_d   = 1'b1;
            div_start = 1'b1;
            div_a     = dd_q;
            div_b     = j_q;
          end else if (found_q && cnt_room) begin
            div_start = 1'b1;
            div_a     = r_q;
            div_b     = j_q;
            state_d   = StRDiv;
          end else begin
            j_d     = j_q + 1'b1;
            jsq_d   = jsq_q + {1'b0, j_q, 1'b0} + 1'b1;
            found_d = 1'b0;
            state_d = StTrial;
          end
        end
      end
      StRDiv: begin
        if (div_done) begin
          r_d     = r_q - dd_q;
          cnt_d   = cnt_q + 1'b1;
          j_d     = j_q + 1'b1;
          jsq_d   = jsq_q + {1'b0, j_q, 1'b0} + 1'b1;
          found_d = 1'b0;
          state_d = StTrial;
        end
      end
      StLast: begin
        // A leftover above one is a single large prime.
        if ((n_q > W'(1)) && cnt_room) begin
          div_start = 1'b1;
          div_a     = r_q;
          div_b     = n_q;
          state_d   = StLastW;
        end else begin
          state_d = StDone;
        end
      end
      StLastW: begin
        if (div_done) begin
          r_d     = r_q - dd_q;
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          res_d       = r_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    x_q     <= x_d;
    y_q     <= y_d;
    n_q     <= n_d;
    r_q     <= r_d;
    j_q     <= j_d;
    jsq_q   <= jsq_d;
    cnt_q   <= cnt_d;
    found_q <= found_d;
    res_q   <= res_d;
    dd_q    <= dd_d;
    dv_q    <= dv_d;
    rem_q   <= rem_d;
  end

endmodule
